// ===== sv/bvl_pkg.sv =====
// shared constants, types and the level curve for battery_voltage_and_level
// no dependencies

package bvl_pkg;

    localparam int ADC_BITS_DEFAULT = 10;
    localparam int MV_BITS          = 16;
    localparam int PCT_BITS         = 7;
    localparam int QBITS_PER_STAGE  = 4;

    localparam logic [MV_BITS-1:0] BANDGAP_RESET = 16'd1100;
    localparam logic [MV_BITS-1:0] MV_MAX        = 16'hFFFF;
    localparam logic [MV_BITS-1:0] FULL_MV       = 16'd3000;
    localparam logic [MV_BITS-1:0] KNEE_HI_MV    = 16'd2880;
    localparam logic [MV_BITS-1:0] KNEE_LO_MV    = 16'd2680;
    localparam logic [MV_BITS-1:0] EMPTY_MV      = 16'd2200;
    localparam logic [MV_BITS-1:0] PCT_FULL      = 16'd100;
    localparam logic [MV_BITS-1:0] PCT_KNEE_HI   = 16'd85;
    localparam logic [MV_BITS-1:0] PCT_KNEE_LO   = 16'd60;

    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } ctl_t;

    function automatic logic [PCT_BITS-1:0] level_of(input logic [MV_BITS-1:0] mv);
        logic [MV_BITS-1:0] pct;
        pct = '0;
        priority if (mv >= FULL_MV)
        begin
            pct = PCT_FULL;
        end
        else if (mv >= KNEE_HI_MV)
        begin
            pct = PCT_FULL - ((FULL_MV - mv) >> 3);
        end
        else if (mv >= KNEE_LO_MV)
        begin
            pct = PCT_KNEE_HI - ((KNEE_HI_MV - mv) >> 3);
        end
        else if (mv >= EMPTY_MV)
        begin
            pct = PCT_KNEE_LO - ((KNEE_LO_MV - mv) >> 3);
        end
        else
        begin
            pct = '0;
        end
        return pct[PCT_BITS-1:0];
    endfunction

endpackage

// ===== sv/battery_voltage_and_level.sv =====
// supply voltage and battery level from a bandgap-against-vcc adc code
// depends on bvl_pkg
//
// One item (adc_code) is taken in every cycle that start is high; busy is always
// low since the pipeline never stalls. Each item gives one result, shown on
// supply_mv and battery_percent for one cycle with done high, after it has
// gone through one input stage, four divider stages that each resolve 4 of the 16
// quotient bits of bandgap_mv * 2^ADC_BITS / adc_code, one saturation stage and
// one stage for the level curve. Results come out in the order items went in,
// and the receiver must take each one in the cycle it appears. A zero code
// gives 0 mV and 0 percent; quotients above 65535 saturate. bandgap_mv is
// written through cfg_we / cfg_wdata and is sampled when an item is taken.

module battery_voltage_and_level #(
    parameter int ADC_BITS = bvl_pkg::ADC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ADC_BITS-1:0]           adc_code,
    input  logic                          cfg_we,
    input  logic [bvl_pkg::MV_BITS-1:0]   cfg_wdata,
    output logic                          done,
    output logic [bvl_pkg::MV_BITS-1:0]   supply_mv,
    output logic [bvl_pkg::PCT_BITS-1:0]  battery_percent
);

    localparam int QW      = bvl_pkg::MV_BITS;
    localparam int DW      = QW + ADC_BITS;
    localparam int STEPS   = bvl_pkg::QBITS_PER_STAGE;
    localparam int NSTG    = QW / STEPS;
    localparam int LATENCY = NSTG + 3;

    logic [QW-1:0] bandgap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bandgap_reg <= bvl_pkg::BANDGAP_RESET;
        end
        else if (cfg_we)
        begin
            bandgap_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // input stage
    logic [DW-1:0] dividend;
    logic [DW-1:0] sat_limit;
    assign dividend  = {bandgap_reg, {ADC_BITS{1'b0}}};
    assign sat_limit = {adc_code, {QW{1'b0}}};

    bvl_pkg::ctl_t       ctl_reg  [NSTG+1];
    logic [ADC_BITS-1:0] code_reg [NSTG+1];
    logic [ADC_BITS-1:0] rem_reg  [NSTG+1];
    logic [QW-1:0]       low_reg  [NSTG+1];
    logic [QW-1:0]       quot_reg [NSTG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0].valid <= start;
            ctl_reg[0].zero  <= (adc_code == '0);
            ctl_reg[0].sat   <= (dividend >= sat_limit);
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg[0] <= adc_code;
        rem_reg[0]  <= dividend[DW-1:QW];
        low_reg[0]  <= dividend[QW-1:0];
        quot_reg[0] <= '0;
    end

    // divider stages
    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        logic [ADC_BITS-1:0] rem_next;
        logic [QW-1:0]       low_next;
        logic [QW-1:0]       quot_next;

        always_comb
        begin
            logic [ADC_BITS:0] trial;
            rem_next  = rem_reg[k];
            low_next  = low_reg[k];
            quot_next = quot_reg[k];
            for (int j = 0; j < STEPS; j++)
            begin
                trial    = {rem_next, low_next[QW-1]};
                low_next = {low_next[QW-2:0], 1'b0};
                if (trial >= {1'b0, code_reg[k]})
                begin
                    trial     = trial - {1'b0, code_reg[k]};
                    quot_next = {quot_next[QW-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_next[QW-2:0], 1'b0};
                end
                rem_next = trial[ADC_BITS-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            code_reg[k+1] <= code_reg[k];
            rem_reg[k+1]  <= rem_next;
            low_reg[k+1]  <= low_next;
            quot_reg[k+1] <= quot_next;
        end
    end

    // saturation stage
    logic          mv_valid_reg;
    logic [QW-1:0] mv_reg;
    logic [QW-1:0] mv_next;

    always_comb
    begin
        priority if (ctl_reg[NSTG].zero)
        begin
            mv_next = '0;
        end
        else if (ctl_reg[NSTG].sat)
        begin
            mv_next = bvl_pkg::MV_MAX;
        end
        else
        begin
            mv_next = quot_reg[NSTG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_valid_reg <= 1'b0;
        end
        else
        begin
            mv_valid_reg <= ctl_reg[NSTG].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg <= mv_next;
    end

    // level stage and output registers
    logic                         done_reg;
    logic [QW-1:0]                supply_mv_reg;
    logic [bvl_pkg::PCT_BITS-1:0] battery_percent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        supply_mv_reg       <= mv_reg;
        battery_percent_reg <= bvl_pkg::level_of(mv_reg);
    end

    assign done            = done_reg;
    assign supply_mv       = supply_mv_reg;
    assign battery_percent = battery_percent_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item did not come out after the pipeline latency");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (battery_percent <= 7'd100))
        else $error("battery percent above 100");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (supply_mv >= bvl_pkg::FULL_MV)) |-> (battery_percent == 7'd100))
        else $error("full supply not reported as 100 percent");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (supply_mv < bvl_pkg::EMPTY_MV)) |-> (battery_percent == 7'd0))
        else $error("low supply not reported as 0 percent");

endmodule
